// ===== rtl/core/pftm_pkg.sv =====
// Package for the perspective floor texel mapper.
// Holds the screen and texture constants, field widths, register codes and shared types.
// No dependencies; used by pftm_divider and perspective_floor_texel_mapper_top.
`default_nettype none

package pftm_pkg;

  // Screen and texture geometry.
  localparam int unsigned SCREEN_WIDTH  = 320;
  localparam int unsigned SCREEN_HEIGHT = 200;
  localparam int unsigned TEXTURE_SIZE  = 64;
  localparam int unsigned CHECKER_CELL  = 8;

  localparam int unsigned HALF_WIDTH = SCREEN_WIDTH / 2;
  localparam int unsigned TEX_BITS   = $clog2(TEXTURE_SIZE);
  localparam int unsigned CELL_BIT   = $clog2(CHECKER_CELL);

  // Port widths.
  localparam int unsigned COL_W      = 9;
  localparam int unsigned ROW_W      = 8;
  localparam int unsigned HEIGHT_W   = 8;
  localparam int unsigned POS_W      = 24;
  localparam int unsigned TRIG_W     = 16;
  localparam int unsigned SHADE_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Fixed-point formats: positions Q.8, trig Q2.14, world sums Q.22.
  localparam int unsigned POS_FRAC  = 8;
  localparam int unsigned TRIG_FRAC = 14;
  localparam int unsigned SUM_FRAC  = POS_FRAC + TRIG_FRAC;

  // Datapath widths.
  localparam int unsigned DIFF_W     = COL_W + 1;
  localparam int unsigned MAG_W      = COL_W;
  localparam int unsigned PROD_W     = MAG_W + HEIGHT_W;
  localparam int unsigned DIVIDEND_W = PROD_W + POS_FRAC;
  localparam int unsigned DIVISOR_W  = ROW_W;
  localparam int unsigned DX_W       = DIVIDEND_W + 1;
  localparam int unsigned XPROD_W    = DX_W + TRIG_W;
  localparam int unsigned DPROD_W    = ROW_W + 1 + TRIG_W;
  localparam int unsigned SUM_W      = XPROD_W + 2;

  // Divider: a fixed number of quotient bits is resolved in each stage.
  localparam int unsigned DIV_BITS_PER_STAGE = 5;
  localparam int unsigned DIV_STAGES         = DIVIDEND_W / DIV_BITS_PER_STAGE;

  // Two front stages, the divider, then sign, multiply, sum and output stages.
  localparam int unsigned PIPE_LATENCY = DIV_STAGES + 6;

  localparam logic [SUM_W-1:0] TRUNC_BIAS = SUM_W'((64'd1 << SUM_FRAC) - 64'd1);

  localparam logic [SHADE_W-1:0] SHADE_LIGHT = SHADE_W'(220);
  localparam logic [SHADE_W-1:0] SHADE_DARK  = SHADE_W'(60);

  // Register reset values.
  localparam logic [ROW_W-1:0]    HORIZON_RESET = ROW_W'(SCREEN_HEIGHT / 3);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET  = HEIGHT_W'(40);
  localparam logic [TRIG_W-1:0]   COSINE_RESET  = TRIG_W'(16384);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HORIZON = 3'd0,
    CFG_HEIGHT  = 3'd1,
    CFG_CAM_X   = 3'd2,
    CFG_CAM_Y   = 3'd3,
    CFG_COSINE  = 3'd4,
    CFG_SINE    = 3'd5
  } cfg_idx_e;

  // Side information that travels alongside the divider.
  typedef struct packed {
    logic ground;
    logic neg;
  } div_side_t;

  // Partial remainder and the shared dividend/quotient shift register.
  typedef struct packed {
    logic [DIVISOR_W-1:0]  rem;
    logic [DIVIDEND_W-1:0] work;
  } div_step_t;

endpackage

`default_nettype wire

// ===== rtl/core/pftm_divider.sv =====
// Pipelined unsigned restoring divider for the lateral offset of the texel mapper.
// Resolves a fixed number of quotient bits per stage and carries side data along.
// Depends on pftm_pkg.
`default_nettype none

module pftm_divider (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic [pftm_pkg::DIVIDEND_W-1:0]      dividend_i,
  input  logic [pftm_pkg::DIVISOR_W-1:0]       divisor_i,
  input  pftm_pkg::div_side_t                  side_i,
  output logic                                 valid_o,
  output logic [pftm_pkg::DIVIDEND_W-1:0]      quotient_o,
  output logic [pftm_pkg::DIVISOR_W-1:0]       divisor_o,
  output pftm_pkg::div_side_t                  side_o
);

  localparam int unsigned LAST = pftm_pkg::DIV_STAGES - 1;

  // Each step shifts one dividend bit into the remainder and one quotient bit into the work word.
  function automatic pftm_pkg::div_step_t div_steps(
    input pftm_pkg::div_step_t           a,
    input logic [pftm_pkg::DIVISOR_W-1:0] den
  );
    pftm_pkg::div_step_t          b;
    logic [pftm_pkg::DIVISOR_W:0] trial;
    b = a;
    for (int i = 0; i < int'(pftm_pkg::DIV_BITS_PER_STAGE); i++) begin
      trial  = {b.rem, b.work[pftm_pkg::DIVIDEND_W-1]};
      b.work = {b.work[pftm_pkg::DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        b.rem     = pftm_pkg::DIVISOR_W'(trial - {1'b0, den});
        b.work[0] = 1'b1;
      end else begin
        b.rem = trial[pftm_pkg::DIVISOR_W-1:0];
      end
    end
    return b;
  endfunction

  logic [pftm_pkg::DIV_STAGES-1:0] vld_q;
  pftm_pkg::div_step_t             step_q [pftm_pkg::DIV_STAGES];
  logic [pftm_pkg::DIVISOR_W-1:0]  den_q  [pftm_pkg::DIV_STAGES];
  pftm_pkg::div_side_t             side_q [pftm_pkg::DIV_STAGES];

  for (genvar s = 0; s < int'(pftm_pkg::DIV_STAGES); s++) begin : g_stage
    pftm_pkg::div_step_t            st_in;
    logic [pftm_pkg::DIVISOR_W-1:0] den_in;
    pftm_pkg::div_side_t            side_in;
    logic                           vld_in;

    if (s == 0) begin : g_first
      assign st_in   = {{pftm_pkg::DIVISOR_W{1'b0}}, dividend_i};
      assign den_in  = divisor_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign st_in   = step_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      step_q[s] <= div_steps(st_in, den_in);
      den_q[s]  <= den_in;
      side_q[s] <= side_in;
    end
  end

  assign valid_o    = vld_q[LAST];
  assign quotient_o = step_q[LAST].work;
  assign divisor_o  = den_q[LAST];
  assign side_o     = side_q[LAST];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ##(pftm_pkg::DIV_STAGES) valid_o)
    else $error("divider lost a transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_i |-> ##(pftm_pkg::DIV_STAGES) !valid_o)
    else $error("divider produced a transaction that never entered");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (divisor_o != '0)) |-> (step_q[LAST].rem < divisor_o))
    else $error("divider remainder not below the divisor");

endmodule

`default_nettype wire

// ===== rtl/core/perspective_floor_texel_mapper_top.sv =====
// Perspective floor texel mapper: one screen pixel in, its floor texel and checker shade out.
// Top level with configuration registers and the arithmetic pipeline around the divider.
// Depends on pftm_pkg and pftm_divider.
//
// A pixel is taken whenever start_i is high and busy_o is low, one per clock, and its
// result is strobed on done_o; results cannot be held off, so the receiver must take
// each one in the cycle it is strobed. The pipeline is the lateral-offset divider,
// five stages of five quotient bits each, plus two stages in front of it and four
// behind it (sign, rotation products, world sums, texel and shade). busy_o is high
// only during reset and the first cycle after it. Rows at or above the horizon come
// out as sky with zero shade and texel. The registers are written through cfg_we_i
// and should only change while no pixel is in flight.
`default_nettype none

module perspective_floor_texel_mapper_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [pftm_pkg::COL_W-1:0]          pixel_column_i,
  input  logic [pftm_pkg::ROW_W-1:0]          pixel_row_i,
  input  logic                                cfg_we_i,
  input  logic [pftm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pftm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output logic                                done_o,
  output logic                                is_ground_o,
  output logic [pftm_pkg::SHADE_W-1:0]        shade_o,
  output logic [pftm_pkg::TEX_BITS-1:0]       texel_u_o,
  output logic [pftm_pkg::TEX_BITS-1:0]       texel_v_o
);

  // Configuration registers.
  logic        [pftm_pkg::ROW_W-1:0]    horizon_q;
  logic        [pftm_pkg::HEIGHT_W-1:0] height_q;
  logic signed [pftm_pkg::POS_W-1:0]    cam_x_q;
  logic signed [pftm_pkg::POS_W-1:0]    cam_y_q;
  logic signed [pftm_pkg::TRIG_W-1:0]   cos_q;
  logic signed [pftm_pkg::TRIG_W-1:0]   sin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      horizon_q <= pftm_pkg::HORIZON_RESET;
      height_q  <= pftm_pkg::HEIGHT_RESET;
      cam_x_q   <= '0;
      cam_y_q   <= '0;
      cos_q     <= pftm_pkg::COSINE_RESET;
      sin_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pftm_pkg::CFG_HORIZON: horizon_q <= cfg_wdata_i[pftm_pkg::ROW_W-1:0];
        pftm_pkg::CFG_HEIGHT:  height_q  <= cfg_wdata_i[pftm_pkg::HEIGHT_W-1:0];
        pftm_pkg::CFG_CAM_X:   cam_x_q   <= cfg_wdata_i[pftm_pkg::POS_W-1:0];
        pftm_pkg::CFG_CAM_Y:   cam_y_q   <= cfg_wdata_i[pftm_pkg::POS_W-1:0];
        pftm_pkg::CFG_COSINE:  cos_q     <= cfg_wdata_i[pftm_pkg::TRIG_W-1:0];
        pftm_pkg::CFG_SINE:    sin_q     <= cfg_wdata_i[pftm_pkg::TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  logic busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;

  logic accept;
  assign accept = start_i & ~busy_q;

  // Stage 1: horizon test, forward distance and signed column offset.
  logic signed [pftm_pkg::DIFF_W-1:0] diff_d;
  logic        [pftm_pkg::MAG_W-1:0]  mag_d;

  assign diff_d = $signed({1'b0, pixel_column_i})
                - $signed(pftm_pkg::DIFF_W'(pftm_pkg::HALF_WIDTH));
  assign mag_d  = diff_d[pftm_pkg::DIFF_W-1] ? pftm_pkg::MAG_W'(-diff_d)
                                             : pftm_pkg::MAG_W'(diff_d);

  logic                           p1_vld_q;
  logic                           p1_ground_q;
  logic                           p1_neg_q;
  logic [pftm_pkg::ROW_W-1:0]     p1_dist_q;
  logic [pftm_pkg::MAG_W-1:0]     p1_mag_q;

  // Stage 2: magnitude times camera height.
  logic                           p2_vld_q;
  pftm_pkg::div_side_t            p2_side_q;
  logic [pftm_pkg::ROW_W-1:0]     p2_dist_q;
  logic [pftm_pkg::PROD_W-1:0]    p2_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= accept;
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_ground_q      <= pixel_row_i > horizon_q;
    p1_neg_q         <= diff_d[pftm_pkg::DIFF_W-1];
    p1_dist_q        <= pixel_row_i - horizon_q;
    p1_mag_q         <= mag_d;
    p2_side_q.ground <= p1_ground_q;
    p2_side_q.neg    <= p1_neg_q;
    p2_dist_q        <= p1_dist_q;
    p2_prod_q        <= pftm_pkg::PROD_W'(p1_mag_q) * pftm_pkg::PROD_W'(height_q);
  end

  // Lateral offset magnitude in Q.8, truncated.
  logic                              div_vld;
  logic [pftm_pkg::DIVIDEND_W-1:0]   div_quo;
  logic [pftm_pkg::DIVISOR_W-1:0]    div_den;
  pftm_pkg::div_side_t               div_side;

  pftm_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (p2_vld_q),
    .dividend_i ({p2_prod_q, {pftm_pkg::POS_FRAC{1'b0}}}),
    .divisor_i  (p2_dist_q),
    .side_i     (p2_side_q),
    .valid_o    (div_vld),
    .quotient_o (div_quo),
    .divisor_o  (div_den),
    .side_o     (div_side)
  );

  // Stage 3: restore the sign; truncation toward zero falls out of the unsigned division.
  logic signed [pftm_pkg::DX_W-1:0] dx_mag;
  assign dx_mag = $signed({1'b0, div_quo});

  logic                              p3_vld_q;
  logic                              p3_ground_q;
  logic [pftm_pkg::ROW_W-1:0]        p3_dist_q;
  logic signed [pftm_pkg::DX_W-1:0]  p3_dx_q;

  // Stage 4: rotation products.
  logic signed [pftm_pkg::ROW_W:0]     dist_s;
  assign dist_s = $signed({1'b0, p3_dist_q});

  logic                                p4_vld_q;
  logic                                p4_ground_q;
  logic signed [pftm_pkg::XPROD_W-1:0] p4_xc_q;
  logic signed [pftm_pkg::XPROD_W-1:0] p4_xs_q;
  logic signed [pftm_pkg::DPROD_W-1:0] p4_dc_q;
  logic signed [pftm_pkg::DPROD_W-1:0] p4_ds_q;

  // Stage 5: world coordinates in Q.22.
  logic                                p5_vld_q;
  logic                                p5_ground_q;
  logic signed [pftm_pkg::SUM_W-1:0]   p5_wx_q;
  logic signed [pftm_pkg::SUM_W-1:0]   p5_wy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_vld_q <= 1'b0;
      p4_vld_q <= 1'b0;
      p5_vld_q <= 1'b0;
    end else begin
      p3_vld_q <= div_vld;
      p4_vld_q <= p3_vld_q;
      p5_vld_q <= p4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p3_ground_q <= div_side.ground;
    p3_dist_q   <= div_den;
    p3_dx_q     <= div_side.neg ? -dx_mag : dx_mag;

    p4_ground_q <= p3_ground_q;
    p4_xc_q     <= pftm_pkg::XPROD_W'(p3_dx_q) * pftm_pkg::XPROD_W'(cos_q);
    p4_xs_q     <= pftm_pkg::XPROD_W'(p3_dx_q) * pftm_pkg::XPROD_W'(sin_q);
    p4_dc_q     <= pftm_pkg::DPROD_W'(dist_s) * pftm_pkg::DPROD_W'(cos_q);
    p4_ds_q     <= pftm_pkg::DPROD_W'(dist_s) * pftm_pkg::DPROD_W'(sin_q);

    p5_ground_q <= p4_ground_q;
    p5_wx_q     <= (pftm_pkg::SUM_W'(cam_x_q) <<< pftm_pkg::TRIG_FRAC)
                 + pftm_pkg::SUM_W'(p4_xc_q)
                 - (pftm_pkg::SUM_W'(p4_ds_q) <<< pftm_pkg::POS_FRAC);
    p5_wy_q     <= (pftm_pkg::SUM_W'(cam_y_q) <<< pftm_pkg::TRIG_FRAC)
                 + pftm_pkg::SUM_W'(p4_xs_q)
                 + (pftm_pkg::SUM_W'(p4_dc_q) <<< pftm_pkg::POS_FRAC);
  end

  // Stage 6: truncate toward zero by biasing negative sums before the shift; the low
  // bits of the two's complement integer are then the non-negative texture wrap.
  logic [pftm_pkg::SUM_W-1:0]    wx_adj;
  logic [pftm_pkg::SUM_W-1:0]    wy_adj;
  logic [pftm_pkg::TEX_BITS-1:0] u_d;
  logic [pftm_pkg::TEX_BITS-1:0] v_d;

  assign wx_adj = p5_wx_q + (p5_wx_q[pftm_pkg::SUM_W-1] ? pftm_pkg::TRUNC_BIAS : '0);
  assign wy_adj = p5_wy_q + (p5_wy_q[pftm_pkg::SUM_W-1] ? pftm_pkg::TRUNC_BIAS : '0);
  assign u_d    = wx_adj[pftm_pkg::SUM_FRAC +: pftm_pkg::TEX_BITS];
  assign v_d    = wy_adj[pftm_pkg::SUM_FRAC +: pftm_pkg::TEX_BITS];

  logic                          done_q;
  logic                          ground_q;
  logic [pftm_pkg::SHADE_W-1:0]  shade_q;
  logic [pftm_pkg::TEX_BITS-1:0] u_q;
  logic [pftm_pkg::TEX_BITS-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= p5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ground_q <= p5_ground_q;
    if (p5_ground_q) begin
      shade_q <= (u_d[pftm_pkg::CELL_BIT] ^ v_d[pftm_pkg::CELL_BIT]) ? pftm_pkg::SHADE_LIGHT
                                                                     : pftm_pkg::SHADE_DARK;
      u_q     <= u_d;
      v_q     <= v_d;
    end else begin
      shade_q <= '0;
      u_q     <= '0;
      v_q     <= '0;
    end
  end

  assign done_o      = done_q;
  assign is_ground_o = ground_q;
  assign shade_o     = shade_q;
  assign texel_u_o   = u_q;
  assign texel_v_o   = v_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(pftm_pkg::PIPE_LATENCY) done_o)
    else $error("accepted transaction did not complete on time");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> !busy_o)
    else $error("busy raised outside reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !is_ground_o) |-> ((shade_o == '0) && (texel_u_o == '0) && (texel_v_o == '0)))
    else $error("sky result carries texel data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_ground_o) |->
      (shade_o == ((texel_u_o[pftm_pkg::CELL_BIT] ^ texel_v_o[pftm_pkg::CELL_BIT])
                   ? pftm_pkg::SHADE_LIGHT : pftm_pkg::SHADE_DARK)))
    else $error("floor shade does not match the checker cell");

endmodule

`default_nettype wire
